/* rtl/htlp_pkg.sv */
// Shared constants, types and a helper function of the linear-probe hash table.
package htlp_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int KEY_BYTES     = 8;
  localparam int VALUE_BYTES   = 8;

  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int HASH_W   = 32;
  localparam int PROD_W   = 2 * HASH_W;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 8;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RED_W = IDX_W + 1;
  localparam int CNT_W = ($clog2(TABLE_ENTRIES + 1) > USED_W) ?
                         $clog2(TABLE_ENTRIES + 1) : USED_W;
  localparam bit TABLE_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  // Floor of 2^32 over the table size, for the reciprocal slot reduction.
  localparam logic [HASH_W-1:0] HASH_RECIP =
      HASH_W'((64'd1 << HASH_W) / 64'(TABLE_ENTRIES));

  localparam logic [VAL_W-1:0] VALUE_MASK = (VALUE_BYTES >= 8) ? {VAL_W{1'b1}} :
      ((VAL_W'(1) << (8 * VALUE_BYTES)) - VAL_W'(1));

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_CHECK
  } htlp_state_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_MIX,
    HS_QUOT,
    HS_REDUCE,
    HS_DONE
  } htlp_hstate_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } htlp_home_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } htlp_entry_t;

  typedef struct packed {
    logic             en;
    logic             set_occ;
    logic [IDX_W-1:0] addr;
    htlp_entry_t      entry;
  } htlp_wr_t;

  // Keeps the characters up to the first zero byte and within KEY_BYTES.
  function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] kept;
    logic             keep;
    kept = '0;
    keep = 1'b1;
    for (int pos = 0; pos < 8; pos++) begin
      keep = keep && (pos < KEY_BYTES) && (raw[pos*8 +: 8] != 8'd0);
      if (keep) begin
        kept[pos*8 +: 8] = raw[pos*8 +: 8];
      end
    end
    return kept;
  endfunction

endpackage

/* rtl/hash_table_linear_probe.sv */
// Top level of the open-addressing hash table with linear probing.
// The key is hashed one character at a time, then each slot probed passes through the
// issue and check states, the result register loading at the end of the last probe; with a
// table size that is not a power of two the slot reduction adds a quotient and a reduce step.
// One transaction at a time: a new request is taken once the last result is loaded.
// Reset clears the occupied marks and the entry count at once; no clearing pass is needed.
module hash_table_linear_probe (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [htlp_pkg::KEY_W-1:0]      in_key_chars,
  input  logic [htlp_pkg::VAL_W-1:0]      in_value_word,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [htlp_pkg::STATUS_W-1:0]   out_status,
  output logic [htlp_pkg::VAL_W-1:0]      out_value_out,
  output logic [htlp_pkg::USED_W-1:0]     out_entries_used
);

  htlp_pkg::htlp_state_t state_r, state_nxt;

  // Request held for the whole transaction.
  logic                         op_r;
  logic [htlp_pkg::KEY_W-1:0]   key_r;
  logic [htlp_pkg::VAL_W-1:0]   val_r;

  // Probe position and the number of slots already passed over.
  logic [htlp_pkg::IDX_W-1:0]   at_r;
  logic [htlp_pkg::IDX_W-1:0]   probe_r;
  logic [htlp_pkg::CNT_W-1:0]   cnt_r;

  // Result register, which lets the result wait while the next request is accepted.
  logic                         out_valid_r;
  logic [htlp_pkg::STATUS_W-1:0] out_status_r;
  logic [htlp_pkg::VAL_W-1:0]   out_value_r;
  logic [htlp_pkg::USED_W-1:0]  out_used_r;

  logic                         in_accept;
  logic                         out_free;
  logic                         hash_start;
  htlp_pkg::htlp_home_t         home;
  htlp_pkg::htlp_wr_t           wr;
  htlp_pkg::htlp_entry_t        rd_entry;
  logic                         rd_occ;

  // Probe decision, valid in the check state.
  logic                         slot_empty;
  logic                         key_match;
  logic                         last_probe;
  logic                         finish;
  logic                         fire;
  logic [htlp_pkg::STATUS_W-1:0] status_c;
  logic [htlp_pkg::VAL_W-1:0]   value_c;
  logic [htlp_pkg::CNT_W-1:0]   cnt_c;
  logic [htlp_pkg::IDX_W-1:0]   at_next;

  htlp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (htlp_pkg::clean_key(in_key_chars)),
    .home  (home)
  );

  // The read address is always the current probe slot; the read issued in the
  // issue state returns in the check state, and nothing writes in between.
  htlp_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (at_r),
    .wr       (wr),
    .rd_entry (rd_entry),
    .rd_occ   (rd_occ)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign slot_empty = !rd_occ;
  assign key_match  = (rd_entry.key == key_r);
  assign last_probe = (probe_r == htlp_pkg::IDX_W'(htlp_pkg::TABLE_ENTRIES - 1));
  assign finish     = slot_empty || key_match || last_probe;
  assign at_next    = (at_r == htlp_pkg::IDX_W'(htlp_pkg::TABLE_ENTRIES - 1)) ?
                      '0 : at_r + htlp_pkg::IDX_W'(1);

  // Result of the slot just read. A free slot ends the search before the key is
  // compared, so an unwritten entry never decides anything.
  always_comb begin
    value_c = '0;
    cnt_c   = cnt_r;
    if (slot_empty) begin
      if (op_r == htlp_pkg::OP_INSERT) begin
        status_c = htlp_pkg::STS_INSERTED;
        cnt_c    = cnt_r + htlp_pkg::CNT_W'(1);
      end else begin
        status_c = htlp_pkg::STS_NOT_FOUND;
      end
    end else if (key_match) begin
      if (op_r == htlp_pkg::OP_INSERT) begin
        status_c = htlp_pkg::STS_UPDATED;
      end else begin
        status_c = htlp_pkg::STS_FOUND;
        value_c  = rd_entry.value;
      end
    end else begin
      // A whole sweep passed without a free slot or the key.
      status_c = (op_r == htlp_pkg::OP_INSERT) ? htlp_pkg::STS_FULL :
                                                 htlp_pkg::STS_NOT_FOUND;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htlp_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = htlp_pkg::S_HASH;
        end
      end
      htlp_pkg::S_HASH: begin
        if (home.done) begin
          state_nxt = htlp_pkg::S_ISSUE;
        end
      end
      htlp_pkg::S_ISSUE: begin
        state_nxt = htlp_pkg::S_CHECK;
      end
      htlp_pkg::S_CHECK: begin
        if (!finish) begin
          state_nxt = htlp_pkg::S_ISSUE;
        end else if (out_free) begin
          state_nxt = htlp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = htlp_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs. A finished search waits in the check state, with no write,
  // until the result register can take the result.
  always_comb begin
    in_stall   = (state_r != htlp_pkg::S_IDLE);
    hash_start = (state_r == htlp_pkg::S_IDLE) && in_valid;
    fire       = (state_r == htlp_pkg::S_CHECK) && finish && out_free;

    wr.en          = fire && (op_r == htlp_pkg::OP_INSERT) && (slot_empty || key_match);
    wr.set_occ     = slot_empty;
    wr.addr        = at_r;
    wr.entry.key   = key_r;
    wr.entry.value = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htlp_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        cnt_r       <= cnt_c;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_operation;
      key_r <= htlp_pkg::clean_key(in_key_chars);
      val_r <= in_value_word & htlp_pkg::VALUE_MASK;
    end
    if ((state_r == htlp_pkg::S_HASH) && home.done) begin
      at_r    <= home.slot;
      probe_r <= '0;
    end else if ((state_r == htlp_pkg::S_CHECK) && !finish) begin
      at_r    <= at_next;
      probe_r <= probe_r + htlp_pkg::IDX_W'(1);
    end
    if (fire) begin
      out_status_r <= status_c;
      out_value_r  <= value_c;
      // The count saturates at the top of the eight-bit field.
      out_used_r   <= (cnt_c > htlp_pkg::CNT_W'(255)) ? 8'd255 : cnt_c[htlp_pkg::USED_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_value_out    = out_value_r;
  assign out_entries_used = out_used_r;

endmodule

/* rtl/htlp_hash.sv */
// Home slot unit: djb2 hash one character per cycle, then reduction to a slot.
module htlp_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [htlp_pkg::KEY_W-1:0]    key,
  output htlp_pkg::htlp_home_t          home
);

  htlp_pkg::htlp_hstate_t state_r, state_nxt;

  logic [htlp_pkg::HASH_W-1:0]    h_r;
  logic [htlp_pkg::KEY_W-1:0]     kbuf_r;
  logic [htlp_pkg::HASH_W-1:0]    quot_r;
  logic [htlp_pkg::IDX_W-1:0]     slot_r;

  logic [7:0]                     ch;
  logic [htlp_pkg::HASH_W-1:0]    h_mix;
  logic [htlp_pkg::PROD_W-1:0]    quot_prod;
  logic [htlp_pkg::RED_W-1:0]     red_t;
  logic [htlp_pkg::RED_W-1:0]     red_sub;

  assign ch    = kbuf_r[7:0];
  assign h_mix = (h_r << htlp_pkg::HASH_SHIFT) + h_r + htlp_pkg::HASH_W'(ch);

  // The reciprocal estimate of the quotient is low by at most one, so the remainder it
  // leaves is below twice the table size and its low RED_W bits are the whole of it.
  assign quot_prod = htlp_pkg::PROD_W'(h_r) * htlp_pkg::PROD_W'(htlp_pkg::HASH_RECIP);
  assign red_t     = h_r[htlp_pkg::RED_W-1:0] -
                     quot_r[htlp_pkg::RED_W-1:0] * htlp_pkg::RED_W'(htlp_pkg::TABLE_ENTRIES);

  always_comb begin
    if (red_t >= htlp_pkg::RED_W'(htlp_pkg::TABLE_ENTRIES)) begin
      red_sub = red_t - htlp_pkg::RED_W'(htlp_pkg::TABLE_ENTRIES);
    end else begin
      red_sub = red_t;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htlp_pkg::HS_IDLE: begin
        if (start) begin
          state_nxt = htlp_pkg::HS_MIX;
        end
      end
      htlp_pkg::HS_MIX: begin
        if (ch == 8'd0) begin
          state_nxt = htlp_pkg::TABLE_POW2 ? htlp_pkg::HS_DONE : htlp_pkg::HS_QUOT;
        end
      end
      htlp_pkg::HS_QUOT: begin
        state_nxt = htlp_pkg::HS_REDUCE;
      end
      htlp_pkg::HS_REDUCE: begin
        state_nxt = htlp_pkg::HS_DONE;
      end
      htlp_pkg::HS_DONE: begin
        state_nxt = htlp_pkg::HS_IDLE;
      end
      default: begin
        state_nxt = htlp_pkg::HS_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    home.done = (state_r == htlp_pkg::HS_DONE);
    home.slot = slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htlp_pkg::HS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      htlp_pkg::HS_IDLE: begin
        if (start) begin
          h_r    <= htlp_pkg::HASH_START;
          kbuf_r <= key;
        end
      end
      htlp_pkg::HS_MIX: begin
        if (ch == 8'd0) begin
          slot_r <= h_r[htlp_pkg::IDX_W-1:0];
        end else begin
          h_r    <= h_mix;
          kbuf_r <= kbuf_r >> 8;
        end
      end
      htlp_pkg::HS_QUOT: begin
        quot_r <= quot_prod[htlp_pkg::PROD_W-1:htlp_pkg::HASH_W];
      end
      htlp_pkg::HS_REDUCE: begin
        slot_r <= red_sub[htlp_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/htlp_store.sv */
// Slot storage: key and value memory with registered read, plus occupied marks.
module htlp_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [htlp_pkg::IDX_W-1:0]   rd_addr,
  input  htlp_pkg::htlp_wr_t           wr,
  output htlp_pkg::htlp_entry_t        rd_entry,
  output logic                         rd_occ
);

  htlp_pkg::htlp_entry_t mem [htlp_pkg::TABLE_ENTRIES];
  logic [htlp_pkg::TABLE_ENTRIES-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

  // The occupied marks are flip-flops so that reset clears them at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      rd_occ <= 1'b0;
    end else begin
      if (wr.en && wr.set_occ) begin
        occ_r[wr.addr] <= 1'b1;
      end
      rd_occ <= occ_r[rd_addr];
    end
  end

endmodule
